### hdl/dgd_pkg.sv
// Shared types, constants and the key table of the DTMF Goertzel detector.
package dgd_pkg;

  localparam int NumTones   = 8;
  localparam int StateBits  = 48;
  localparam int MaxFrame   = 4096;
  localparam int CountBits  = 13;
  localparam int MagBits    = 56;
  localparam int AccBits    = 112;
  localparam int MacABits   = 64;
  localparam int MacSteps   = 56;
  localparam int CfgIdxBits = 4;

  localparam logic signed [15:0] CoefReset [NumTones] = '{
    16'sd27979, 16'sd26956, 16'sd25702, 16'sd24219,
    16'sd19073, 16'sd16325, 16'sd13085, 16'sd9315
  };

  localparam logic [7:0] KeyTable [16] = '{
    8'h31, 8'h32, 8'h33, 8'h41,
    8'h34, 8'h35, 8'h36, 8'h42,
    8'h37, 8'h38, 8'h39, 8'h43,
    8'h2a, 8'h30, 8'h23, 8'h44
  };

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  digit_char;
    logic [1:0]  row_index;
    logic [1:0]  col_index;
    logic [31:0] confidence;
    logic        frame_overflow;
  } out_item_t;

  // Command to the serial multiply-accumulate unit
  typedef struct packed {
    logic start;
    logic clear;
    logic subtract;
  } mac_cmd_t;

  function automatic logic [7:0] key_char(logic [1:0] r, logic [1:0] c);
    return KeyTable[{r, c}];
  endfunction

endpackage

### hdl/dgd_serial_mac.sv
// Shift-and-add multiply-accumulate unit, one multiplier bit per cycle.
module dgd_serial_mac (
  input  logic                          clk,
  input  logic                          rst,
  input  dgd_pkg::mac_cmd_t             cmd,
  input  logic [dgd_pkg::MacABits-1:0]  a,
  input  logic [dgd_pkg::MagBits-1:0]   b,
  output logic                          busy,
  output logic [dgd_pkg::AccBits-1:0]   acc
);
  import dgd_pkg::*;

  logic [AccBits-1:0] a_sh;
  logic [MagBits-1:0] b_sh;
  logic               sub;
  logic [5:0]         cnt;

  assign busy = (cnt != 6'd0);

  // Load operands on start, then add or subtract one shifted partial product a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 6'd0;
    end else if (cmd.start) begin
      a_sh <= {{(AccBits-MacABits){1'b0}}, a};
      b_sh <= b;
      sub  <= cmd.subtract;
      cnt  <= 6'(MacSteps);
      if (cmd.clear) begin
        acc <= '0;
      end
    end else if (busy) begin
      if (b_sh[0]) begin
        acc <= sub ? acc - a_sh : acc + a_sh;
      end
      a_sh <= {a_sh[AccBits-2:0], 1'b0};
      b_sh <= {1'b0, b_sh[MagBits-1:1]};
      cnt  <= cnt - 6'd1;
    end
  end

endmodule

### hdl/dtmf_goertzel_detector_unit.sv
// Top level of the DTMF Goertzel detector: sequencer, resonator state and result register.
//
// Each sample item is accepted, then takes a multiply and an update for each of
// the eight tones, all through one 16x48 multiplier with the resonator state held
// in rotating register rings. The item that carries last_sample also runs the
// end-of-frame work before the next item is taken: per tone one multiply, three
// passes of the serial multiply-accumulate unit and a bit-serial square root,
// then sixteen score products and a division, which is skipped when the
// confidence saturates. A frame of fewer than two samples skips this and reports
// key '1' with zero confidence. The result sits in an output register, so a new
// frame may start while it waits.
module dtmf_goertzel_detector_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dgd_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dgd_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [dgd_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [15:0]                     cfg_data
);
  import dgd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_ADD, E_CHK, E_CS, E_Q1, E_W1, E_Q2, E_W2, E_Q3, E_W3,
    E_SQ, E_SQI, E_LDR, E_LDC, E_SC, E_WSC, E_NSQ, E_SAT, E_DIV, E_FIN
  } state_t;

  state_t                   state;
  logic signed [15:0]       coef [NumTones];
  logic signed [StateBits-1:0] d1 [NumTones];
  logic signed [StateBits-1:0] d2 [NumTones];
  logic [MagBits-1:0]       mag [NumTones];
  logic [CountBits-1:0]     count;
  logic                     ovf;
  logic                     last_q;
  logic signed [15:0]       x;
  logic [2:0]               k;
  logic signed [63:0]       prod;
  logic [AccBits-1:0]       sq_q;
  logic [MagBits+1:0]       sq_rem;
  logic [MagBits-1:0]       root;
  logic [5:0]               step;
  logic [1:0]               r;
  logic [1:0]               c;
  logic [MagBits-1:0]       mr;
  logic [MagBits-1:0]       mc;
  logic [AccBits-1:0]       best;
  logic [1:0]               best_r;
  logic [1:0]               best_c;
  logic [24:0]              nsq;
  logic [24:0]              rem;
  logic [31:0]              div_sh;
  logic [31:0]              conf;

  // Shared multiplier and recursion update
  logic signed [15:0]       coef_sel;
  logic signed [63:0]       prod_next;
  logic signed [51:0]       sum;
  logic signed [StateBits-1:0] s0;
  logic [StateBits-1:0]     abs1;
  logic [StateBits-1:0]     abs2;
  logic [63:0]              abs_p;

  assign coef_sel  = coef[k];
  assign prod_next = coef_sel * d1[0];
  assign sum = {{22{x[15]}}, x, 14'b0} + {{2{prod[63]}}, prod[63:14]}
             - {{4{d2[0][StateBits-1]}}, d2[0]};

  // Saturate the new resonator value to the state width
  always_comb begin
    if (sum[51:StateBits-1] == '0 || sum[51:StateBits-1] == '1) begin
      s0 = sum[StateBits-1:0];
    end else if (sum[51]) begin
      s0 = {1'b1, {(StateBits-1){1'b0}}};
    end else begin
      s0 = {1'b0, {(StateBits-1){1'b1}}};
    end
  end

  assign abs1  = d1[0][StateBits-1] ? StateBits'(-d1[0]) : StateBits'(d1[0]);
  assign abs2  = d2[0][StateBits-1] ? StateBits'(-d2[0]) : StateBits'(d2[0]);
  assign abs_p = prod[63] ? 64'(-prod) : 64'(prod);

  // Drive the serial multiply-accumulate unit from the sequencer state
  mac_cmd_t           mac_cmd;
  logic [MacABits-1:0] mac_a;
  logic [MagBits-1:0]  mac_b;
  logic               mac_busy;
  logic [AccBits-1:0] mac_acc;

  always_comb begin
    mac_cmd = '0;
    mac_a   = '0;
    mac_b   = '0;
    case (state)
      E_Q1: begin
        mac_cmd.start = 1'b1;
        mac_cmd.clear = 1'b1;
        mac_a = {2'b0, abs1, 14'b0};
        mac_b = {8'b0, abs1};
      end
      E_Q2: begin
        mac_cmd.start = 1'b1;
        mac_a = {2'b0, abs2, 14'b0};
        mac_b = {8'b0, abs2};
      end
      E_Q3: begin
        mac_cmd.start    = 1'b1;
        mac_cmd.subtract = ~(prod[63] ^ d2[0][StateBits-1]);
        mac_a = abs_p;
        mac_b = {8'b0, abs2};
      end
      E_SC: begin
        mac_cmd.start = 1'b1;
        mac_cmd.clear = 1'b1;
        mac_a = {8'b0, mr};
        mac_b = mc;
      end
      default: begin
        mac_cmd = '0;
      end
    endcase
  end

  dgd_serial_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mac_cmd),
    .a    (mac_a),
    .b    (mac_b),
    .busy (mac_busy),
    .acc  (mac_acc)
  );

  // Square root step, division step, magnitude read port, frame length squared
  logic [MagBits+3:0] sq_cand;
  logic [MagBits+3:0] sq_trial;
  logic [25:0]        div_cand;
  logic [2:0]         m_idx;
  logic [25:0]        nsq_full;

  assign sq_cand  = {sq_rem, sq_q[AccBits-1:AccBits-2]};
  assign sq_trial = {2'b0, root, 2'b01};
  assign div_cand = {rem, div_sh[31]};
  assign m_idx    = (state == E_LDR) ? {1'b0, r} : {1'b1, c};
  assign nsq_full = {13'b0, count} * {13'b0, count};

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      ovf       <= 1'b0;
      k         <= '0;
      for (int i = 0; i < NumTones; i++) begin
        coef[i] <= CoefReset[i];
        d1[i]   <= '0;
        d2[i]   <= '0;
      end
    end else begin
      // Drop the result once taken, unless a new one replaces it now
      if (out_valid && !out_stall && state != E_FIN) begin
        out_valid <= 1'b0;
      end
      // Register writes
      if (cfg_we && cfg_index < CfgIdxBits'(NumTones)) begin
        coef[cfg_index[2:0]] <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_q <= in_data.last_sample;
            x      <= in_data.sample;
            k      <= '0;
            if (count < CountBits'(MaxFrame)) begin
              state <= S_MUL;
            end else begin
              ovf <= 1'b1;
              if (in_data.last_sample) begin
                state <= E_CHK;
              end
            end
          end
        end
        S_MUL: begin
          prod  <= prod_next;
          state <= S_ADD;
        end
        S_ADD: begin
          // Advance the rings: the updated tone goes to the back
          for (int i = 0; i < NumTones-1; i++) begin
            d1[i] <= d1[i+1];
            d2[i] <= d2[i+1];
          end
          d1[NumTones-1] <= s0;
          d2[NumTones-1] <= d1[0];
          k <= k + 3'd1;
          if (k == 3'(NumTones-1)) begin
            count <= count + CountBits'(1);
            state <= last_q ? E_CHK : S_IDLE;
          end else begin
            state <= S_MUL;
          end
        end
        E_CHK: begin
          best   <= '0;
          best_r <= '0;
          best_c <= '0;
          conf   <= '0;
          k      <= '0;
          state  <= (count < CountBits'(2)) ? E_FIN : E_CS;
        end
        E_CS: begin
          prod  <= prod_next;
          state <= E_Q1;
        end
        E_Q1: state <= E_W1;
        E_W1: if (!mac_busy) state <= E_Q2;
        E_Q2: state <= E_W2;
        E_W2: if (!mac_busy) state <= E_Q3;
        E_Q3: state <= E_W3;
        E_W3: begin
          if (!mac_busy) begin
            sq_q   <= mac_acc;
            sq_rem <= '0;
            root   <= '0;
            step   <= 6'(MagBits);
            state  <= E_SQI;
          end
        end
        E_SQ: state <= E_SQI;
        E_SQI: begin
          // One root bit per cycle
          if (sq_cand >= sq_trial) begin
            sq_rem <= (MagBits+2)'(sq_cand - sq_trial);
            root   <= {root[MagBits-2:0], 1'b1};
          end else begin
            sq_rem <= sq_cand[MagBits+1:0];
            root   <= {root[MagBits-2:0], 1'b0};
          end
          sq_q <= {sq_q[AccBits-3:0], 2'b00};
          step <= step - 6'd1;
          if (step == 6'd0) begin
            mag[k] <= root;
            for (int i = 0; i < NumTones-1; i++) begin
              d1[i] <= d1[i+1];
              d2[i] <= d2[i+1];
            end
            d1[NumTones-1] <= d1[0];
            d2[NumTones-1] <= d2[0];
            k <= k + 3'd1;
            r <= '0;
            c <= '0;
            state <= (k == 3'(NumTones-1)) ? E_LDR : E_CS;
          end
        end
        E_LDR: begin
          mr    <= mag[m_idx];
          state <= E_LDC;
        end
        E_LDC: begin
          mc    <= mag[m_idx];
          state <= E_SC;
        end
        E_SC: state <= E_WSC;
        E_WSC: begin
          if (!mac_busy) begin
            // Keep the first pair on ties
            if (mac_acc > best) begin
              best   <= mac_acc;
              best_r <= r;
              best_c <= c;
            end
            c <= c + 2'd1;
            if (c == 2'd3) begin
              r     <= r + 2'd1;
              state <= (r == 2'd3) ? E_NSQ : E_LDR;
            end else begin
              state <= E_LDC;
            end
          end
        end
        E_NSQ: begin
          nsq   <= nsq_full[24:0];
          state <= E_SAT;
        end
        E_SAT: begin
          if (best[AccBits-1:74] >= {13'b0, nsq}) begin
            conf  <= '1;
            state <= E_FIN;
          end else begin
            rem    <= best[98:74];
            div_sh <= best[73:42];
            step   <= 6'd31;
            state  <= E_DIV;
          end
        end
        E_DIV: begin
          // Restoring division, one quotient bit per cycle
          if (div_cand >= {1'b0, nsq}) begin
            rem    <= 25'(div_cand - {1'b0, nsq});
            div_sh <= {div_sh[30:0], 1'b1};
          end else begin
            rem    <= div_cand[24:0];
            div_sh <= {div_sh[30:0], 1'b0};
          end
          step <= step - 6'd1;
          if (step == 6'd0) begin
            conf  <= (div_cand >= {1'b0, nsq}) ? {div_sh[30:0], 1'b1}
                                                : {div_sh[30:0], 1'b0};
            state <= E_FIN;
          end
        end
        E_FIN: begin
          // Hold until the output register is free, then clear the frame
          if (!out_valid || !out_stall) begin
            out_valid               <= 1'b1;
            out_data.digit_char     <= key_char(best_r, best_c);
            out_data.row_index      <= best_r;
            out_data.col_index      <= best_c;
            out_data.confidence     <= conf;
            out_data.frame_overflow <= ovf;
            for (int i = 0; i < NumTones; i++) begin
              d1[i] <= '0;
              d2[i] <= '0;
            end
            count <= '0;
            ovf   <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/dgd_checker.sv
// Checker for the DTMF Goertzel detector: watches the channels, predicts each key result and compares.
module dgd_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  dgd_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  dgd_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [dgd_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  import dgd_pkg::*;

  localparam longint StateHi = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint StateLo = -64'sh0000_7FFF_FFFF_FFFF - 1;

  logic signed [15:0] coeff [NumTones];
  longint             res_s1 [NumTones];
  longint             res_s2 [NumTones];
  int                 frame_len;
  bit                 frame_ovf;
  out_item_t          expected_keys [$];

  // Integer square root of a tone's power, in units of 2^-21 sample
  function automatic longint unsigned tone_mag(int k);
    logic signed [127:0] a, b, c, q;
    logic [127:0]        uq, cand;
    longint unsigned     res;
    a = res_s1[k];
    b = res_s2[k];
    c = coeff[k];
    q = ((a * a + b * b) <<< 14) - c * a * b;
    uq = q;
    res = 0;
    for (int i = 63; i >= 0; i--) begin
      cand = {64'b0, res} | (128'd1 << i);
      if (cand * cand <= uq) res = cand[63:0];
    end
    return res;
  endfunction

  // Clear the resonators for the next frame
  task automatic clear_frame();
    for (int k = 0; k < NumTones; k++) begin
      res_s1[k] = 0;
      res_s2[k] = 0;
    end
    frame_len = 0;
    frame_ovf = 0;
  endtask

  // Advance all resonators by one sample unless the frame is full; on the last one queue the key result
  task automatic predict_sample(in_item_t it);
    longint          x, s0;
    longint unsigned mag [NumTones];
    logic [127:0]    best, sc, v;
    logic [1:0]      br, bc;
    out_item_t       r;
    if (frame_len < MaxFrame) begin
      x = longint'(it.sample) <<< 14;
      for (int k = 0; k < NumTones; k++) begin
        s0 = x + ((longint'(coeff[k]) * res_s1[k]) >>> 14) - res_s2[k];
        if (s0 > StateHi) s0 = StateHi;
        if (s0 < StateLo) s0 = StateLo;
        res_s2[k] = res_s1[k];
        res_s1[k] = s0;
      end
      frame_len++;
    end else begin
      frame_ovf = 1;
    end
    if (!it.last_sample) return;
    best = 0;
    br = 0;
    bc = 0;
    r.confidence = 0;
    if (frame_len >= 2) begin
      for (int k = 0; k < NumTones; k++) mag[k] = tone_mag(k);
      for (int ri = 0; ri < 4; ri++) begin
        for (int ci = 0; ci < 4; ci++) begin
          sc = {64'b0, mag[ri]} * {64'b0, mag[4 + ci]};
          if (sc > best) begin
            best = sc;
            br = ri[1:0];
            bc = ci[1:0];
          end
        end
      end
      v = (best >> 42) / (frame_len * frame_len);
      r.confidence = (v > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    end
    r.digit_char = KeyTable[{br, bc}];
    r.row_index = br;
    r.col_index = bc;
    r.frame_overflow = frame_ovf;
    expected_keys.push_back(r);
    clear_frame();
  endtask

  // Compare one accepted key result with the oldest prediction
  task automatic check_key(out_item_t got);
    out_item_t e;
    if (expected_keys.size() == 0) begin
      $error("unexpected result item %p", got);
      fail_count++;
      return;
    end
    e = expected_keys.pop_front();
    if (got.digit_char !== e.digit_char) begin
      $error("digit_char: expected %h, actual %h", e.digit_char, got.digit_char);
      fail_count++;
    end
    if (got.row_index !== e.row_index) begin
      $error("row_index: expected %0d, actual %0d", e.row_index, got.row_index);
      fail_count++;
    end
    if (got.col_index !== e.col_index) begin
      $error("col_index: expected %0d, actual %0d", e.col_index, got.col_index);
      fail_count++;
    end
    if (got.confidence !== e.confidence) begin
      $error("confidence: expected %0d, actual %0d", e.confidence, got.confidence);
      fail_count++;
    end
    if (got.frame_overflow !== e.frame_overflow) begin
      $error("frame_overflow: expected %b, actual %b", e.frame_overflow, got.frame_overflow);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Track configuration, predict on accepted samples, check accepted results
  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NumTones; k++) coeff[k] = CoefReset[k];
      clear_frame();
      expected_keys.delete();
    end else begin
      if (cfg_we && cfg_index < NumTones) coeff[cfg_index[2:0]] = cfg_data;
      if (in_valid && !in_stall) predict_sample(in_data);
      if (out_valid && !out_stall) check_key(out_data);
    end
    pending = expected_keys.size();
  end

endmodule

### tb/tb_dtmf_goertzel_detector_unit.sv
// Testbench top of the DTMF Goertzel detector: clock, reset, stimulus and verdict.
module tb_dtmf_goertzel_detector_unit;
  import dgd_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_we;
  logic [CfgIdxBits-1:0] cfg_index;
  logic [15:0] cfg_data;
  int        fail_count;
  int        pending;

  bit        idle_on;
  int        hold_cycles;

  dtmf_goertzel_detector_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dgd_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 9);
    end
  end

  // Offer one sample item and hold it until accepted
  task automatic send_sample(logic signed [15:0] s, logic last);
    while (idle_on && $urandom_range(99) < 9) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data.sample <= s;
    in_data.last_sample <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Pick a sample: full range, small, or an extreme
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      1: return $signed(16'($urandom_range(511))) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // Send a frame of random samples
  task automatic send_frame(int len);
    for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  // Send a frame of one constant sample value
  task automatic send_const_frame(int len, logic signed [15:0] s);
    for (int i = 0; i < len; i++) send_sample(s, i == len - 1);
  endtask

  // Drain every result and let the block settle before a register write
  task automatic wait_idle();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(int idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx[CfgIdxBits-1:0];
    cfg_data <= val;
    @(negedge clk);
  endtask

  // Random frame lengths: mostly short, some single samples, rare long ones
  task automatic random_frames(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(19))
        0: len = 1;
        1: len = $urandom_range(100, 300);
        default: len = $urandom_range(2, 12);
      endcase
      send_frame(len);
      sent += len;
    end
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    idle_on = 1;
    hold_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed frames at the reset coefficients
    send_const_frame(1, 16'sh7FFF);
    send_const_frame(1, 16'sh8000);
    send_const_frame(4, 16'sd0);
    send_sample(16'sh7FFF, 0);
    send_sample(16'sh8000, 1);
    for (int i = 0; i < 8; i++) send_sample((i % 2) ? 16'sh8000 : 16'sh7FFF, i == 7);
    send_frame(6);

    // Setting phases, extremes first
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      for (int k = 0; k < NumTones; k++) begin
        case (p)
          0: write_reg(k, 16'h7FFF);
          1: write_reg(k, 16'h8000);
          2: write_reg(k, 16'h0000);
          default: write_reg(k, 16'($urandom));
        endcase
      end
      write_reg($urandom_range(NumTones, 15), 16'($urandom));
      cfg_we <= 0;
      @(negedge clk);
      idle_on = (p != 3);
      if (p == 0) send_const_frame(100, 16'sh7FFF);
      if (p == 4) begin
        hold_cycles <= 8000;
        send_const_frame(2, 16'sh8000);
      end
      random_frames(120);
    end

    wait_idle();
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
